[rtl/aes128_ctr_keystream_defines.svh]
// Assertion macros for the AES-128 CTR keystream block.
// Used by the top level only; no other dependencies.
`ifndef AES128_CTR_KEYSTREAM_DEFINES_SVH
`define AES128_CTR_KEYSTREAM_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ACK_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ACK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ack_pkg.sv]
// Package for the AES-128 CTR keystream block: types, S-box and round functions.
// No dependencies.
package ack_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int PADDR_W    = 5;

    localparam logic [PADDR_W-1:0] ADDR_KEY_HIGH    = 5'h00;
    localparam logic [PADDR_W-1:0] ADDR_KEY_LOW     = 5'h08;
    localparam logic [PADDR_W-1:0] ADDR_NONCE_FRONT = 5'h10;
    localparam logic [PADDR_W-1:0] ADDR_NONCE_MID   = 5'h18;

    typedef logic [127:0] block_t;

    // Data handed from one round cell to the next.
    typedef struct packed {
        logic   valid;
        logic   last;
        block_t state;
        block_t rkey;
        logic [7:0] rcon;
    } stage_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[127-8*i -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
            t[119-32*c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
            t[111-32*c -: 8]  = a2 ^ all ^ xtime(a2 ^ a3);
            t[103-32*c -: 8]  = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic block_t next_rkey(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[rtl/ack_round_cell.sv]
// One AES round cell: round transform plus on-the-fly key schedule step.
// Depends on ack_pkg.
module ack_round_cell #(
    parameter bit FINAL = 1'b0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  ack_pkg::stage_t stage_in,
    output ack_pkg::stage_t stage_out
);
    import ack_pkg::*;

    stage_t stage_reg;
    stage_t stage_next;
    block_t rk;
    block_t mixed;

    always_comb begin
        rk    = next_rkey(stage_in.rkey, stage_in.rcon);
        mixed = FINAL ? sub_shift(stage_in.state)
                      : mix_columns(sub_shift(stage_in.state));
        stage_next.valid = stage_in.valid;
        stage_next.last  = stage_in.last;
        stage_next.state = mixed ^ rk;
        stage_next.rkey  = rk;
        stage_next.rcon  = xtime(stage_in.rcon);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= stage_next.valid;
        end
        if (advance) begin
            stage_reg.last  <= stage_next.last;
            stage_reg.state <= stage_next.state;
            stage_reg.rkey  <= stage_next.rkey;
            stage_reg.rcon  <= stage_next.rcon;
        end
    end

    assign stage_out = stage_reg;

endmodule

[rtl/aes128_ctr_keystream.sv]
// Top level of the AES-128 CTR keystream generator.
// Depends on ack_pkg, ack_round_cell and aes128_ctr_keystream_defines.svh.
//
//  port group | direction | tdata fields (low bit first)            | tlast
//  s_axis     | in        | start_counter, block_index               | last_in
//  m_axis     | out       | keystream_high, keystream_low            | last_out
//  apb        | in        | key_high, key_low, nonce_front, nonce_mid| -
//
// A request enters at most once per cycle and passes 11 register stages: a first register for
// counter add and initial key addition, then ten round cells, the last of which drives the output.
// The whole chain advances together and halts while the output holds an unread result.
// Reset is synchronous and clears only the valid bits and the configuration registers.
`include "aes128_ctr_keystream_defines.svh"
module aes128_ctr_keystream (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // start_counter [31:0], block_index [63:32]
    input  logic [63:0]               s_axis_tdata,
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // keystream_high [63:0], keystream_low [127:64]
    output logic [127:0]              m_axis_tdata,
    output logic                      m_axis_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ack_pkg::PADDR_W-1:0] paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);
    import ack_pkg::*;

    logic [63:0] key_high_reg, key_low_reg, nonce_front_reg;
    logic [31:0] nonce_mid_reg;
    logic        cfg_we;
    logic        advance;
    logic [63:0] ctr;
    stage_t      first_reg;
    stage_t      first_next;
    stage_t      chain [NUM_ROUNDS+1];
    block_t      key_blk;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            nonce_front_reg <= '0;
            nonce_mid_reg   <= '0;
        end else if (cfg_we) begin
            case (paddr)
                ADDR_KEY_HIGH:    key_high_reg    <= pwdata;
                ADDR_KEY_LOW:     key_low_reg     <= pwdata;
                ADDR_NONCE_FRONT: nonce_front_reg <= pwdata;
                ADDR_NONCE_MID:   nonce_mid_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_KEY_HIGH:    prdata = key_high_reg;
            ADDR_KEY_LOW:     prdata = key_low_reg;
            ADDR_NONCE_FRONT: prdata = nonce_front_reg;
            ADDR_NONCE_MID:   prdata = {32'd0, nonce_mid_reg};
            default:          prdata = '0;
        endcase
    end

    assign advance       = !chain[NUM_ROUNDS].valid || m_axis_tready;
    assign s_axis_tready = advance;
    assign key_blk       = {key_high_reg, key_low_reg};
    assign ctr = {nonce_mid_reg, s_axis_tdata[31:0]} + {32'd0, s_axis_tdata[63:32]};

    always_comb begin
        first_next.valid = s_axis_tvalid;
        first_next.last  = s_axis_tlast;
        first_next.state = {nonce_front_reg, ctr} ^ key_blk;
        first_next.rkey  = key_blk;
        first_next.rcon  = 8'h01;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg.valid <= 1'b0;
        end else if (advance) begin
            first_reg.valid <= first_next.valid;
        end
        if (advance) begin
            first_reg.last  <= first_next.last;
            first_reg.state <= first_next.state;
            first_reg.rkey  <= first_next.rkey;
            first_reg.rcon  <= first_next.rcon;
        end
    end

    assign chain[0] = first_reg;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        ack_round_cell #(
            .FINAL(g == NUM_ROUNDS - 1)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .stage_in (chain[g]),
            .stage_out(chain[g+1])
        );
    end

    assign m_axis_tvalid = chain[NUM_ROUNDS].valid;
    assign m_axis_tdata  = {chain[NUM_ROUNDS].state[63:0], chain[NUM_ROUNDS].state[127:64]};
    assign m_axis_tlast  = chain[NUM_ROUNDS].last;

    `ACK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ACK_ASSERT_IMP(a_ready_rule, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
    `ACK_ASSERT_NEXT(a_chain_stall, aclk, aresetn, !advance, $stable(chain[0].valid), "first stage moved during stall")

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the AES-128 CTR keystream generator.
// Drives requests and APB writes, predicts each keystream block; needs ack_pkg and the RTL.
module tb_top;
    import ack_pkg::*;

    localparam int PIPE_DEPTH = 12;

    typedef struct {
        logic [63:0] ks_high;
        logic [63:0] ks_low;
        logic        last;
    } keystream_t;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [127:0]        m_axis_tdata;
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    logic [63:0] key_high_q, key_low_q, nonce_front_q;
    logic [31:0] nonce_mid_q;
    logic [7:0]  sbox_tab [256];

    keystream_t  expected_blocks [$];
    int          mismatches;
    int          stall_cycles;
    bit          src_idle_en;
    bit          sink_idle_en;

    aes128_ctr_keystream dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // The S-box is derived from the field inverse followed by the affine map.
    function automatic logic [7:0] sbox_entry(input logic [7:0] x);
        logic [7:0] inv, b;
        inv = 8'h01;
        if (x == 8'h00) inv = 8'h00;
        else for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
        b = inv;
        return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                 ^ {b[3:0], b[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
        return b[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] round_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*c) -: 8] = sbox_tab[byte_at(s, r + 4*((c + r) % 4))];
        return t;
    endfunction

    function automatic logic [127:0] round_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, x;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(s, 4*c);
            a1 = byte_at(s, 4*c+1);
            a2 = byte_at(s, 4*c+2);
            a3 = byte_at(s, 4*c+3);
            x  = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 8] = a0 ^ x ^ dbl(a0 ^ a1);
            t[119-32*c -: 8] = a1 ^ x ^ dbl(a1 ^ a2);
            t[111-32*c -: 8] = a2 ^ x ^ dbl(a2 ^ a3);
            t[103-32*c -: 8] = a3 ^ x ^ dbl(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        {w0, w1, w2, w3} = k;
        g  = {sbox_tab[w3[23:16]] ^ rc, sbox_tab[w3[15:8]], sbox_tab[w3[7:0]],
              sbox_tab[w3[31:24]]};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic keystream_t predict_keystream(input logic [31:0] start_ctr,
                                                     input logic [31:0] blk_idx,
                                                     input logic last);
        logic [63:0]  ctr;
        logic [127:0] st, rk;
        logic [7:0]   rc;
        keystream_t   res;
        ctr = {nonce_mid_q, start_ctr} + {32'd0, blk_idx};
        rk  = {key_high_q, key_low_q};
        st  = {nonce_front_q, ctr} ^ rk;
        rc  = 8'h01;
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            st = round_sub_shift(st);
            if (r < NUM_ROUNDS) st = round_mix(st);
            rk = key_step(rk, rc);
            rc = dbl(rc);
            st = st ^ rk;
        end
        res.ks_high = st[127:64];
        res.ks_low  = st[63:0];
        res.last    = last;
        return res;
    endfunction

    // Result checker: compares each accepted block with the oldest expectation.
    always @(posedge aclk) begin
        keystream_t exp_blk;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected block: high=%h low=%h last=%b",
                             m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tlast);
            end else begin
                exp_blk = expected_blocks.pop_front();
                if (m_axis_tdata[63:0] !== exp_blk.ks_high ||
                    m_axis_tdata[127:64] !== exp_blk.ks_low ||
                    m_axis_tlast !== exp_blk.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h %h %b, got %h %h %b",
                                 exp_blk.ks_high, exp_blk.ks_low, exp_blk.last,
                                 m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tlast);
                end
            end
        end
    end

    // The receiver stalls at random when enabled, or for a counted stretch when asked; else it is ready.
    always @(posedge aclk) begin
        if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en) begin
            m_axis_tready <= ($urandom_range(99) >= 21);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [31:0] start_ctr, input logic [31:0] blk_idx,
                                input logic last);
        if (src_idle_en && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk_idx, start_ctr};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        expected_blocks.push_back(predict_keystream(start_ctr, blk_idx, last));
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_KEY_HIGH:    key_high_q    = data;
            ADDR_KEY_LOW:     key_low_q     = data;
            ADDR_NONCE_FRONT: nonce_front_q = data;
            ADDR_NONCE_MID:   nonce_mid_q   = data[31:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [63:0] nf, input logic [31:0] nm);
        drain_pipeline();
        apb_write(ADDR_KEY_HIGH, kh);
        apb_write(ADDR_KEY_LOW, kl);
        apb_write(ADDR_NONCE_FRONT, nf);
        apb_write(ADDR_NONCE_MID, {$urandom(), nm});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_reset_defaults();
        send_request(32'h0, 32'h0, 1'b0);
        send_request(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    endtask

    task automatic test_field_extremes();
        set_config('1, '1, '1, '1);
        send_request(32'h0, 32'h0, 1'b1);
        send_request(32'hffff_ffff, 32'h0, 1'b0);
        send_request(32'h0, 32'hffff_ffff, 1'b1);
        send_request(32'haaaa_5555, 32'h5555_aaaa, 1'b0);
        set_config(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                   64'h8000_0000_0000_0001, 32'h8000_0001);
        for (int i = 0; i < 6; i++)
            send_request(32'h1234_5678, i, i == 5);
    endtask

    task automatic test_counter_wrap();
        set_config(rand64(), rand64(), 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        send_request(32'hffff_ffff, 32'h0, 1'b0);
        send_request(32'hffff_ffff, 32'h1, 1'b0);
        send_request(32'hffff_fffe, 32'hffff_ffff, 1'b0);
        send_request(32'h8000_0000, 32'h8000_0000, 1'b1);
        set_config(rand64(), rand64(), 64'h0, 32'h0000_0000);
        send_request(32'hffff_ffff, 32'h1, 1'b1);
        send_request(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    endtask

    task automatic test_random_requests(input int n_items);
        int sent, len;
        logic [31:0] start_ctr, base;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 400 == 0)
                set_config(rand64(), rand64(), rand64(), $urandom());
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(1, 8);
                start_ctr = $urandom();
                base = ($urandom_range(3) == 0) ? $urandom() : 32'h0;
                for (int i = 0; i < len; i++)
                    send_request(start_ctr, base + i, i == len - 1);
                sent += len;
            end else begin
                send_request($urandom(), $urandom(), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        drain_pipeline();
        src_idle_en = 1'b0;
        stall_cycles = 300;
        for (int i = 0; i < 60; i++)
            send_request($urandom(), i, i % 4 == 3);
        src_idle_en = 1'b1;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        key_high_q    = '0;
        key_low_q     = '0;
        nonce_front_q = '0;
        nonce_mid_q   = '0;
        mismatches    = 0;
        stall_cycles  = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_entry(i[7:0]);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_field_extremes();
        test_counter_wrap();
        test_output_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_requests(250);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_random_requests(1500);

        drain_pipeline();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[aes128_ctr_keystream.f]
+incdir+rtl
rtl/ack_pkg.sv
rtl/ack_round_cell.sv
rtl/aes128_ctr_keystream.sv
test/tb_top.sv
